@@ rtl/core/rational_number_alu_unit_macros.svh @@
// assertion macros for the rational number alu
// used by the top level only
`ifndef RATIONAL_NUMBER_ALU_UNIT_MACROS_SVH
`define RATIONAL_NUMBER_ALU_UNIT_MACROS_SVH
// assert that a condition implies a consequence on the same edge
`define RNA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rna check failed");
// assert that a condition implies a consequence on the next edge
`define RNA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rna check failed");
`endif

@@ rtl/core/rna_pkg.sv @@
// package of the rational number alu: opcodes, widths, command and status types
// no dependencies
package rna_pkg;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned ResWidth   = 64;
  localparam int unsigned DefOperandWidth = 32;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_MUL = 2'd1,
    FUNC_EQ  = 2'd2,
    FUNC_RED = 2'd3
  } func_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture operands
    logic mul;      // run one product step
    logic fin_ar;   // form add/mul/eq result
    logic gcd_init; // set up euclid on magnitudes
    logic div_init; // start a remainder or quotient division
    logic div_step; // one restoring division bit
    logic gcd_swap; // x <- y, y <- remainder
    logic quot_sel; // 0 euclid remainder division, 1 quotient division
    logic quot_sav; // store quotient
    logic fin_red;  // form reduce result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       is_red;
    logic       y_zero;
    logic       div_last;
    logic [1:0] mul_cnt;
  } stat_t;
endpackage

@@ rtl/core/rna_if.sv @@
// valid/ready channel carrying an item payload of any type
// depends on nothing; the payload type is a parameter
interface rna_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rna_datapath.sv @@
// datapath of the rational number alu: product unit, euclid and divider
// depends on rna_pkg
module rna_datapath #(
  parameter int unsigned OperandWidth = rna_pkg::DefOperandWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rna_pkg::cmd_t             cmd_i,
  output rna_pkg::stat_t            stat_o,
  input  logic [1:0]                func_i,
  input  logic [rna_pkg::FieldWidth-1:0] a_num_i,
  input  logic [rna_pkg::FieldWidth-1:0] a_den_i,
  input  logic [rna_pkg::FieldWidth-1:0] b_num_i,
  input  logic [rna_pkg::FieldWidth-1:0] b_den_i,
  output logic [rna_pkg::ResWidth-1:0]   res_num_o,
  output logic [rna_pkg::ResWidth-1:0]   res_den_o,
  output logic                      is_equal_o,
  output logic                      zero_gcd_o
);
  localparam int unsigned W  = OperandWidth;
  localparam int unsigned RW = rna_pkg::ResWidth;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [1:0]    func_q;
  logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic [1:0]    mcnt_q;
  logic [W-1:0]  x_q, y_q, g_q;
  logic [W-1:0]  dvd_q, dvs_q, quo_q;
  logic [W:0]    rem_q;
  logic [CW-1:0] dcnt_q;
  logic [W-1:0]  qn_q;
  logic [RW-1:0] rn_q, rd_q;
  logic          eq_q, zg_q;

  // one signed product per step, selected by the step counter
  logic signed [W-1:0]  m_a, m_b;
  logic signed [PW-1:0] m_p;
  always_comb begin
    case (mcnt_q)
      2'd0:    begin m_a = an_q; m_b = bd_q; end
      2'd1:    begin m_a = bn_q; m_b = ad_q; end
      2'd2:    begin m_a = ad_q; m_b = bd_q; end
      default: begin m_a = an_q; m_b = bn_q; end
    endcase
    m_p = PW'(m_a) * PW'(m_b);
  end

  function automatic logic [RW-1:0] sx(input logic [PW-1:0] v);
    sx = RW'($signed(v));
  endfunction
  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (W'(0) - v) : v;
  endfunction

  // restoring division step
  logic [W:0] rem_sh;
  logic [W:0] rem_sub;
  always_comb begin
    rem_sh  = {rem_q[W-1:0], dvd_q[W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= 2'd0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) mcnt_q <= 2'd0;
      else if (cmd_i.mul) mcnt_q <= mcnt_q + 2'd1;
      if (cmd_i.div_init) dcnt_q <= CW'(W);
      else if (cmd_i.div_step) dcnt_q <= dcnt_q - CW'(1);
    end
  end

  // operand, product, euclid, divider and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      an_q <= a_num_i[W-1:0];
      ad_q <= a_den_i[W-1:0];
      bn_q <= b_num_i[W-1:0];
      bd_q <= b_den_i[W-1:0];
    end
    if (cmd_i.mul) begin
      case (mcnt_q)
        2'd0:    p0_q <= m_p;
        2'd1:    p1_q <= m_p;
        2'd2:    p2_q <= m_p;
        default: p3_q <= m_p;
      endcase
    end
    if (cmd_i.fin_ar) begin
      eq_q <= 1'b0;
      zg_q <= 1'b0;
      case (func_q)
        rna_pkg::FUNC_ADD: begin
          rn_q <= sx(p0_q) + sx(p1_q);
          rd_q <= sx(p2_q);
        end
        rna_pkg::FUNC_MUL: begin
          rn_q <= sx(p3_q);
          rd_q <= sx(p2_q);
        end
        default: begin
          rn_q <= '0;
          rd_q <= '0;
          eq_q <= (p0_q == p1_q);
        end
      endcase
    end
    // g always tracks x, the current gcd candidate
    if (cmd_i.gcd_init) begin
      x_q <= mag(an_q);
      y_q <= mag(ad_q);
      g_q <= mag(an_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
      if (cmd_i.quot_sel) begin
        dvd_q <= cmd_i.gcd_swap ? mag(ad_q) : mag(an_q);
        dvs_q <= g_q;
      end else begin
        dvd_q <= x_q;
        dvs_q <= y_q;
        g_q   <= x_q;
      end
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      if (!rem_sub[W]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end else if (cmd_i.gcd_swap) begin
      x_q <= y_q;
      y_q <= rem_q[W-1:0];
      g_q <= y_q;
    end
    if (cmd_i.quot_sav) qn_q <= quo_q;
    if (cmd_i.fin_red) begin
      eq_q <= 1'b0;
      zg_q <= (g_q == '0);
      if (g_q == '0) begin
        rn_q <= RW'($signed(an_q));
        rd_q <= RW'($signed(ad_q));
      end else begin
        rn_q <= an_q[W-1] ? (RW'(0) - RW'(qn_q)) : RW'(qn_q);
        rd_q <= ad_q[W-1] ? (RW'(0) - RW'(quo_q)) : RW'(quo_q);
      end
    end
  end

  assign stat_o.is_red   = (func_q == rna_pkg::FUNC_RED);
  assign stat_o.y_zero   = (y_q == '0);
  assign stat_o.div_last = (dcnt_q == CW'(1));
  assign stat_o.mul_cnt  = mcnt_q;

  assign res_num_o  = rn_q;
  assign res_den_o  = rd_q;
  assign is_equal_o = eq_q;
  assign zero_gcd_o = zg_q;
endmodule

@@ rtl/core/rna_ctrl.sv @@
// controller state machine of the rational number alu
// depends on rna_pkg
module rna_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rna_pkg::stat_t stat_i,
  output rna_pkg::cmd_t  cmd_o
);
  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_MUL   = 12'b000000000010,
    ST_FIN   = 12'b000000000100,
    ST_GINIT = 12'b000000001000,
    ST_GTEST = 12'b000000010000,
    ST_GDIV  = 12'b000000100000,
    ST_GSWAP = 12'b000001000000,
    ST_NDIV  = 12'b000010000000,
    ST_DINIT = 12'b000100000000,
    ST_DDIV  = 12'b001000000000,
    ST_RFIN  = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (stat_i.is_red) begin
          state_d = ST_GINIT;
        end else begin
          cmd_o.mul = 1'b1;
          if (stat_i.mul_cnt == 2'd3) state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin_ar = 1'b1;
        state_d = ST_OUT;
      end
      ST_GINIT: begin
        cmd_o.gcd_init = 1'b1;
        state_d = ST_GTEST;
      end
      ST_GTEST: begin
        // y is zero: x holds the gcd
        cmd_o.div_init = 1'b1;
        if (stat_i.y_zero) begin
          cmd_o.quot_sel = 1'b1;
          state_d = ST_NDIV;
        end else begin
          state_d = ST_GDIV;
        end
      end
      ST_GDIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_GSWAP;
      end
      // move divisor and remainder down one place
      ST_GSWAP: begin
        cmd_o.gcd_swap = 1'b1;
        state_d = ST_GTEST;
      end
      ST_NDIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DINIT;
        end
      end
      // keep the numerator quotient, start on the denominator
      ST_DINIT: begin
        cmd_o.quot_sav = 1'b1;
        cmd_o.div_init = 1'b1;
        cmd_o.quot_sel = 1'b1;
        cmd_o.gcd_swap = 1'b1;
        state_d = ST_DDIV;
      end
      ST_DDIV: begin
        if (stat_i.div_last) state_d = ST_RFIN;
        cmd_o.div_step = 1'b1;
      end
      ST_RFIN: begin
        cmd_o.fin_red = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule

@@ rtl/core/rational_number_alu_unit.sv @@
// Rational number ALU, top level.
// Channels: in_if (func, a_num, a_den, b_num, b_den) and out_if (res_num, res_den,
// is_equal, zero_gcd), both valid/ready; a transfer happens when both are high.
// One item is worked at a time.
// Add, multiply and equality run four product steps on one shared
// OperandWidth x OperandWidth multiplier, then a result step.
// Reduce runs Euclid with a bit-serial restoring divider of OperandWidth steps
// per remainder plus a swap and a test step, then two more divisions for the
// quotients; Euclid takes up to about 46 remainder steps for 32 bits.
// The next item can be accepted in the cycle after the result transfer.
// Reset (rst_ni low, asynchronous) returns the controller to idle with no
// valid result; no clearing pass is needed.
// A stalled receiver holds the result and its valid; input ready stays low.
`include "rational_number_alu_unit_macros.svh"
module rational_number_alu_unit #(
  parameter int unsigned OperandWidth = rna_pkg::DefOperandWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  rna_if.sink   in_if,
  rna_if.source out_if
);
  rna_pkg::cmd_t  cmd;
  rna_pkg::stat_t stat;
  logic in_ready, out_valid;

  rna_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rna_datapath #(.OperandWidth(OperandWidth)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .func_i     (in_if.data.func),
    .a_num_i    (in_if.data.a_num),
    .a_den_i    (in_if.data.a_den),
    .b_num_i    (in_if.data.b_num),
    .b_den_i    (in_if.data.b_den),
    .res_num_o  (out_if.data.res_num),
    .res_den_o  (out_if.data.res_den),
    .is_equal_o (out_if.data.is_equal),
    .zero_gcd_o (out_if.data.zero_gcd)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  // never ready for input while a result is pending
  `RNA_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  // an input transfer is never followed by an immediate result
  `RNA_ASSERT_NXT(a_no_early, in_if.valid && in_ready, !out_valid)
  // the reduce flag and the equality flag are exclusive
  `RNA_ASSERT_IMP(a_flags_excl, out_valid, !(out_if.data.is_equal && out_if.data.zero_gcd))
endmodule
